// ===== rtl/sdf_pkg.sv =====
// Shared types for the stream duplicate filter: the beat token that walks the cell row.
package sdf_pkg;

  localparam int unsigned ValueW = 32;

  typedef struct packed {
    logic              vld;
    logic [ValueW-1:0] value;
    logic              last;
    logic              found;
    logic              stored;
  } sdf_token_t;

endpackage

// ===== rtl/sdf_cell.sv =====
// One table cell: holds one stored value, compares or captures the passing token.
module sdf_cell
  import sdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       live_i,
  input  sdf_token_t token_i,
  output sdf_token_t token_o
);

  sdf_token_t        token_q;
  logic [ValueW-1:0] entry_q;
  logic              hit;
  logic              capture;

  assign hit     = token_q.vld && live_i && (entry_q == token_q.value);
  assign capture = token_q.vld && !live_i && !token_q.found && !token_q.stored;

  always_comb begin
    token_o        = token_q;
    token_o.found  = token_q.found | hit;
    token_o.stored = token_q.stored | capture;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
    end else if (en_i) begin
      token_q <= token_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && capture) begin
      entry_q <= token_q.value;
    end
  end

endmodule

// ===== rtl/stream_duplicate_filter_core.sv =====
// Top level of the stream duplicate filter: cell row, fill count and output register.
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/s_axis_tready tdata[31:0]=value, tlast=last
//   m_axis    out  m_axis_tvalid/m_axis_tready tdata[31:0]=out_value,
//                                              tuser[0]=keep, tuser[1]=table_full,
//                                              tlast=out_last
//
// One beat at a time walks the row of TABLE_DEPTH cells, one cell per cycle while the
// output is not stalled; its result is then registered into the output register, and
// the next beat is taken only after that handoff.
// Reset empties the table by clearing the fill count; no clearing pass.
// A stalled output holds the row; the next beat is taken while a result waits.
module stream_duplicate_filter_core
  import sdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ValueW-1:0] s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ValueW-1:0] m_axis_tdata,   // [31:0] out_value
  output logic [1:0]        m_axis_tuser,   // [0] keep, [1] table_full
  output logic              m_axis_tlast
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  sdf_token_t             chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] tok_vld;
  logic [TABLE_DEPTH-1:0] live;
  sdf_token_t             tail;
  logic                   en;
  logic                   handoff;
  logic                   accept;

  logic [CntW-1:0]   count_q, count_d;
  logic              busy_q, busy_d;
  logic              m_vld_q, m_vld_d;
  logic [ValueW-1:0] m_data_q;
  logic              m_keep_q, m_full_q, m_last_q;

  assign tail    = chain[TABLE_DEPTH];
  assign handoff = tail.vld && (!m_vld_q || m_axis_tready);
  assign en      = !(tail.vld && m_vld_q && !m_axis_tready);
  assign accept  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !busy_q;

  always_comb begin
    chain[0].vld    = accept;
    chain[0].value  = s_axis_tdata;
    chain[0].last   = s_axis_tlast;
    chain[0].found  = 1'b0;
    chain[0].stored = 1'b0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign live[i]    = count_q > CntW'(i);
    assign tok_vld[i] = chain[i+1].vld;
    sdf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .live_i  (live[i]),
      .token_i (chain[i]),
      .token_o (chain[i+1])
    );
  end

  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    m_vld_d = m_vld_q;
    if (m_vld_q && m_axis_tready) begin
      m_vld_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
    if (handoff) begin
      busy_d  = 1'b0;
      m_vld_d = 1'b1;
      if (tail.last) begin
        count_d = '0;
      end else if (tail.stored) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) begin
      m_data_q <= tail.value;
      m_keep_q <= !tail.found;
      m_full_q <= !tail.found && !tail.stored;
      m_last_q <= tail.last;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = {m_full_q, m_keep_q};
  assign m_axis_tlast  = m_last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_one_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one beat in the cell row");

  a_busy_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (|tok_vld))
    else $error("busy flag disagrees with the cell row");

  a_drop_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && !m_keep_q |-> !m_full_q)
    else $error("dropped beat flagged table full");

  a_store_on_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    handoff && tail.stored |-> count_q < CntW'(TABLE_DEPTH))
    else $error("value stored into a full table");

endmodule

// ===== verif/tb_stream_duplicate_filter_core.sv =====
// Self-checking testbench for stream_duplicate_filter_core: directed and random sequences, scoreboard.
module tb_stream_duplicate_filter_core;
  import sdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth    = 64;
  localparam int unsigned RandomItems   = 450;
  localparam int unsigned WatchdogLimit = 40 * (TableDepth + 1);
  localparam int unsigned DrainCycles   = 2 * (TableDepth + 2);
  localparam int unsigned CalmStart     = 6000;
  localparam int unsigned CalmStop      = 12000;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } seq_beat_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              keep;
    logic              full;
    logic              last;
  } filter_verdict_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [ValueW-1:0] s_axis_tdata;   // [31:0] value
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [ValueW-1:0] m_axis_tdata;   // [31:0] out_value
  logic [1:0]        m_axis_tuser;   // [0] keep, [1] table_full
  logic              m_axis_tlast;

  seq_beat_t         pending_beats[$];
  filter_verdict_t   verdicts_due[$];
  logic [ValueW-1:0] seen_tbl[TableDepth];
  int unsigned       seen_cnt = 0;
  int unsigned       beats_queued;
  int unsigned       beats_taken = 0;
  int unsigned       mismatch_cnt = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       cyc = 0;
  logic              in_taken = 1'b0;

  stream_duplicate_filter_core #(
    .TABLE_DEPTH(TableDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic filter_verdict_t predict_verdict(input seq_beat_t b);
    filter_verdict_t r;
    logic            hit;
    hit = 1'b0;
    for (int unsigned i = 0; i < seen_cnt; i++) begin
      if (seen_tbl[i] == b.value) hit = 1'b1;
    end
    r.value = b.value;
    r.last  = b.last;
    r.keep  = !hit;
    r.full  = 1'b0;
    if (!hit) begin
      if (seen_cnt < TableDepth) begin
        seen_tbl[seen_cnt] = b.value;
        seen_cnt++;
      end else begin
        r.full = 1'b1;
      end
    end
    if (b.last) seen_cnt = 0;
    return r;
  endfunction

  function automatic logic idle_roll();
    if (cyc >= CalmStart && cyc < CalmStop) return 1'b0;
    return $urandom_range(0, 99) < 11;
  endfunction

  task automatic add_beat(input logic [ValueW-1:0] value, input logic last);
    seq_beat_t b;
    b.value = value;
    b.last  = last;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic check_field(input string name, input logic [ValueW-1:0] exp_v,
                             input logic [ValueW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // feed input beats and drive output ready
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_beats.size() > 0 && !idle_roll()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_beats[0].value;
          s_axis_tlast  <= pending_beats[0].last;
          void'(pending_beats.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= $urandom;
          s_axis_tlast  <= 1'($urandom_range(0, 1));
        end
      end
      m_axis_tready <= !idle_roll();
    end
  end

  // observe both channels
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      cyc      <= cyc + 1;
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected output beat: tdata 0x%08h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          check_field("out_value", verdicts_due[0].value, m_axis_tdata);
          check_field("keep", ValueW'(verdicts_due[0].keep), ValueW'(m_axis_tuser[0]));
          check_field("table_full", ValueW'(verdicts_due[0].full),
                      ValueW'(m_axis_tuser[1]));
          check_field("out_last", ValueW'(verdicts_due[0].last), ValueW'(m_axis_tlast));
          void'(verdicts_due.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        verdicts_due.push_back(predict_verdict({s_axis_tdata, s_axis_tlast}));
        beats_taken <= beats_taken + 1;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [ValueW-1:0] used_vals[$];
    logic [ValueW-1:0] pool[$];
    logic [ValueW-1:0] v;
    int unsigned       seq_idx;
    int unsigned       len;
    logic              broken;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    beats_queued  = 0;

    add_beat(32'h8000_0000, 1'b0);
    add_beat(32'h7fff_ffff, 1'b0);
    add_beat(32'h0000_0000, 1'b0);
    add_beat(32'hffff_ffff, 1'b0);
    add_beat(32'h8000_0000, 1'b0);
    add_beat(32'h0000_0000, 1'b0);
    add_beat(32'h5555_5555, 1'b0);
    add_beat(32'haaaa_aaaa, 1'b0);
    add_beat(32'h7fff_ffff, 1'b1);
    add_beat(32'h7fff_ffff, 1'b0);
    add_beat(32'h7fff_ffff, 1'b1);
    add_beat(32'h1234_5678, 1'b1);
    add_beat(32'h0000_0000, 1'b1);
    add_beat(32'hffff_ffff, 1'b0);
    add_beat(32'hfffffffe, 1'b0);
    add_beat(32'hffff_ffff, 1'b1);

    seq_idx = 0;
    while (beats_queued < RandomItems + 16) begin
      if (seq_idx == 3 || seq_idx == 25) begin
        used_vals.delete();
        for (int unsigned i = 0; i < 100; i++) begin
          if (i > 0 && $urandom_range(0, 3) == 0) begin
            v = used_vals[$urandom_range(0, used_vals.size() - 1)];
          end else begin
            v = $urandom;
          end
          used_vals.push_back(v);
          add_beat(v, i == 99);
        end
      end else begin
        pool.delete();
        len    = $urandom_range(1, 12);
        broken = $urandom_range(0, 99) < 15;
        for (int unsigned i = 0; i < $urandom_range(1, 8); i++) begin
          case ($urandom_range(0, 9))
            0:       pool.push_back(32'h8000_0000);
            1:       pool.push_back(32'h7fff_ffff);
            2:       pool.push_back(32'h0000_0000);
            3:       pool.push_back(32'hffff_ffff);
            default: pool.push_back($urandom);
          endcase
        end
        for (int unsigned i = 0; i < len; i++) begin
          v = pool[$urandom_range(0, pool.size() - 1)];
          add_beat(v, broken ? logic'($urandom_range(0, 1)) : logic'(i == len - 1));
        end
      end
      seq_idx++;
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken < beats_queued) @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
